@@ rtl/dll_pkg.sv @@
// ----------------------------------------------------------------------------
// dll_pkg
// Shared types and constants for the linked list block.
// ----------------------------------------------------------------------------
`default_nettype none

package dll_pkg;

    localparam int NODES_DEFAULT = 64;

    typedef enum logic [4:0] {
        ACT_CLEAR     = 5'd0,
        ACT_INSFIRST  = 5'd1,
        ACT_INSLAST   = 5'd2,
        ACT_GOFIRST   = 5'd3,
        ACT_GOLAST    = 5'd4,
        ACT_GETFIRST  = 5'd5,
        ACT_GETLAST   = 5'd6,
        ACT_DELFIRST  = 5'd7,
        ACT_DELLAST   = 5'd8,
        ACT_DELAFTER  = 5'd9,
        ACT_DELBEFORE = 5'd10,
        ACT_INSAFTER  = 5'd11,
        ACT_INSBEFORE = 5'd12,
        ACT_GET       = 5'd13,
        ACT_SET       = 5'd14,
        ACT_NEXT      = 5'd15,
        ACT_PREV      = 5'd16,
        ACT_QUERY     = 5'd17
    } action_t;

    typedef struct packed {
        logic [4:0]         action;
        logic signed [31:0] value_in;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] value_out;
        logic               error;
        logic               cursor_valid;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RDC,
        ST_WAITC,
        ST_PICK,
        ST_RDN,
        ST_WAITN,
        ST_LINK,
        ST_RDFREE,
        ST_WAITFREE,
        ST_INS,
        ST_OUT
    } state_t;

    // Datapath commands from the controller.
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LATCH,
        CMD_RD_CUR,
        CMD_PICK,
        CMD_RD_TGT,
        CMD_UNLINK,
        CMD_RD_FREE,
        CMD_INSERT,
        CMD_SIMPLE
    } cmd_t;

    typedef struct packed {
        logic cur_live;
        logic tgt_live;
        logic is_insert;
        logic is_delete;
        logic need_cur;
    } status_t;

endpackage

`default_nettype wire

@@ rtl/dll_ctrl.sv @@
// ----------------------------------------------------------------------------
// dll_ctrl
// Sequencer for one list operation over the node memories.
// ----------------------------------------------------------------------------
`default_nettype none

module dll_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  wire logic             m_ready,
    input  wire dll_pkg::status_t stat,
    output dll_pkg::cmd_t         cmd
);

    dll_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dll_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = dll_pkg::CMD_NONE;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        case (state_reg)
            dll_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd        = dll_pkg::CMD_LATCH;
                    state_next = dll_pkg::ST_RDC;
                end
            end
            dll_pkg::ST_RDC: begin
                if (stat.need_cur && stat.cur_live) begin
                    cmd        = dll_pkg::CMD_RD_CUR;
                    state_next = dll_pkg::ST_WAITC;
                end else begin
                    state_next = dll_pkg::ST_PICK;
                end
            end
            dll_pkg::ST_WAITC: state_next = dll_pkg::ST_PICK;
            dll_pkg::ST_PICK: begin
                cmd = dll_pkg::CMD_PICK;
                if (stat.is_delete) begin
                    state_next = dll_pkg::ST_RDN;
                end else if (stat.is_insert) begin
                    state_next = dll_pkg::ST_RDFREE;
                end else begin
                    state_next = dll_pkg::ST_LINK;
                end
            end
            dll_pkg::ST_RDN: begin
                if (stat.tgt_live) begin
                    cmd        = dll_pkg::CMD_RD_TGT;
                    state_next = dll_pkg::ST_WAITN;
                end else begin
                    state_next = dll_pkg::ST_OUT;
                end
            end
            dll_pkg::ST_WAITN: state_next = dll_pkg::ST_LINK;
            dll_pkg::ST_LINK: begin
                cmd        = stat.is_delete ? dll_pkg::CMD_UNLINK : dll_pkg::CMD_SIMPLE;
                state_next = dll_pkg::ST_OUT;
            end
            dll_pkg::ST_RDFREE: begin
                cmd        = dll_pkg::CMD_RD_FREE;
                state_next = dll_pkg::ST_WAITFREE;
            end
            dll_pkg::ST_WAITFREE: state_next = dll_pkg::ST_INS;
            dll_pkg::ST_INS: begin
                cmd        = dll_pkg::CMD_INSERT;
                state_next = dll_pkg::ST_OUT;
            end
            dll_pkg::ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = dll_pkg::ST_IDLE;
                end
            end
            default: state_next = dll_pkg::ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/dll_dpath.sv @@
// ----------------------------------------------------------------------------
// dll_dpath
// Node memories, list pointers and free pool for the linked list.
// ----------------------------------------------------------------------------
`default_nettype none

module dll_dpath #(
    parameter int NODES = dll_pkg::NODES_DEFAULT
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire dll_pkg::in_item_t  s_item,
    input  wire dll_pkg::cmd_t      cmd,
    output dll_pkg::status_t        stat,
    output dll_pkg::out_item_t      m_item
);

    localparam int IW = $clog2(NODES);
    localparam int PW = IW + 1;
    localparam logic [PW-1:0] NIL = PW'(NODES);

    logic [31:0]   mem_val  [NODES];
    logic [PW-1:0] mem_next [NODES];
    logic [PW-1:0] mem_prev [NODES];

    logic [PW-1:0] head_reg, tail_reg, cur_reg, free_reg, fresh_reg;
    logic [4:0]    act_reg;
    logic [31:0]   vin_reg;
    logic [31:0]   cval_reg;
    logic [PW-1:0] cnext_reg, cprev_reg, tnext_reg, tprev_reg, fnext_reg;
    logic [PW-1:0] tgt_reg, p_reg, q_reg;
    logic [31:0]   rd_reg;
    logic          err_reg;

    function automatic logic live(input logic [PW-1:0] i);
        live = i < NIL;
    endfunction

    logic [IW-1:0] ri;
    logic [PW-1:0] tgt_sel, p_sel, q_sel;
    logic          ins_sel;

    always_comb begin
        ins_sel = 1'b0;
        tgt_sel = NIL;
        p_sel   = NIL;
        q_sel   = NIL;
        case (act_reg)
            dll_pkg::ACT_INSFIRST: begin
                ins_sel = 1'b1; q_sel = head_reg;
            end
            dll_pkg::ACT_INSLAST: begin
                ins_sel = 1'b1; p_sel = tail_reg;
            end
            dll_pkg::ACT_INSAFTER: begin
                ins_sel = live(cur_reg); p_sel = cur_reg; q_sel = cnext_reg;
            end
            dll_pkg::ACT_INSBEFORE: begin
                ins_sel = live(cur_reg); p_sel = cprev_reg; q_sel = cur_reg;
            end
            dll_pkg::ACT_DELFIRST:  tgt_sel = head_reg;
            dll_pkg::ACT_DELLAST:   tgt_sel = tail_reg;
            dll_pkg::ACT_DELAFTER:  tgt_sel = live(cur_reg) ? cnext_reg : NIL;
            dll_pkg::ACT_DELBEFORE: tgt_sel = live(cur_reg) ? cprev_reg : NIL;
            default: ;
        endcase
    end

    always_comb begin
        stat.cur_live  = live(cur_reg);
        stat.tgt_live  = live(tgt_reg);
        stat.is_insert = act_reg == dll_pkg::ACT_INSFIRST || act_reg == dll_pkg::ACT_INSLAST
                      || act_reg == dll_pkg::ACT_INSAFTER || act_reg == dll_pkg::ACT_INSBEFORE;
        stat.is_delete = act_reg == dll_pkg::ACT_DELFIRST || act_reg == dll_pkg::ACT_DELLAST
                      || act_reg == dll_pkg::ACT_DELAFTER
                      || act_reg == dll_pkg::ACT_DELBEFORE;
        stat.need_cur  = 1'b1;
    end

    assign m_item.value_out    = rd_reg;
    assign m_item.error        = err_reg;
    assign m_item.cursor_valid = live(cur_reg);

    // Memory reads: one registered read port per array.
    always_comb begin
        case (cmd)
            dll_pkg::CMD_RD_CUR:  ri = cur_reg[IW-1:0];
            dll_pkg::CMD_RD_TGT:  ri = tgt_reg[IW-1:0];
            dll_pkg::CMD_RD_FREE: ri = free_reg[IW-1:0];
            dll_pkg::CMD_PICK:    ri = (act_reg == dll_pkg::ACT_GETLAST) ? tail_reg[IW-1:0]
                                                                         : head_reg[IW-1:0];
            default:              ri = head_reg[IW-1:0];
        endcase
    end

    logic [31:0]   rval_reg;
    logic [PW-1:0] rnext_reg, rprev_reg;
    logic [1:0]    rsel_reg;

    always_ff @(posedge aclk) begin
        rval_reg  <= mem_val[ri];
        rnext_reg <= mem_next[ri];
        rprev_reg <= mem_prev[ri];
    end

    // Record which read was requested so the registered read data is captured into the matching registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rsel_reg <= 2'd0;
        end else begin
            case (cmd)
                dll_pkg::CMD_RD_CUR:  rsel_reg <= 2'd1;
                dll_pkg::CMD_RD_TGT:  rsel_reg <= 2'd2;
                dll_pkg::CMD_RD_FREE: rsel_reg <= 2'd3;
                default:              rsel_reg <= 2'd0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (rsel_reg)
            2'd1: begin cval_reg <= rval_reg; cnext_reg <= rnext_reg; cprev_reg <= rprev_reg; end
            2'd2: begin tnext_reg <= rnext_reg; tprev_reg <= rprev_reg; end
            2'd3: fnext_reg <= rnext_reg;
            default: ;
        endcase
        if (cmd == dll_pkg::CMD_LATCH) begin
            act_reg   <= s_item.action;
            vin_reg   <= s_item.value_in;
            cnext_reg <= NIL;
            cprev_reg <= NIL;
        end
        if (cmd == dll_pkg::CMD_PICK) begin
            tgt_reg <= tgt_sel;
            p_reg   <= p_sel;
            q_reg   <= q_sel;
        end
    end

    logic          free_avail;
    logic [PW-1:0] new_n;
    assign free_avail = live(free_reg);
    assign new_n      = free_avail ? free_reg : fresh_reg;

    // Neighbor pointers are written in the cycle after, through a pending slot.
    logic          pn_we_reg, pp_we_reg;
    logic [IW-1:0] pn_a_reg, pp_a_reg;
    logic [PW-1:0] pn_d_reg, pp_d_reg;

    // Memory writes: each array has one write per cycle.
    always_ff @(posedge aclk) begin
        if (cmd == dll_pkg::CMD_INSERT && ins_sel && (free_avail || live(fresh_reg))) begin
            mem_val[new_n[IW-1:0]]  <= vin_reg;
            mem_prev[new_n[IW-1:0]] <= p_reg;
            mem_next[new_n[IW-1:0]] <= q_reg;
        end
        if (cmd == dll_pkg::CMD_SIMPLE && act_reg == dll_pkg::ACT_SET && live(cur_reg)) begin
            mem_val[cur_reg[IW-1:0]] <= vin_reg;
        end
        if (cmd == dll_pkg::CMD_UNLINK) begin
            mem_next[tgt_reg[IW-1:0]] <= free_reg;
        end
        if (pn_we_reg) mem_next[pn_a_reg] <= pn_d_reg;
        if (pp_we_reg) mem_prev[pp_a_reg] <= pp_d_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= NIL;
            tail_reg  <= NIL;
            cur_reg   <= NIL;
            free_reg  <= NIL;
            fresh_reg <= '0;
            pn_we_reg <= 1'b0;
            pp_we_reg <= 1'b0;
            rd_reg    <= '0;
            err_reg   <= 1'b0;
        end else begin
            pn_we_reg <= 1'b0;
            pp_we_reg <= 1'b0;
            case (cmd)
                dll_pkg::CMD_LATCH: begin
                    rd_reg  <= '0;
                    err_reg <= 1'b0;
                end
                dll_pkg::CMD_SIMPLE: begin
                    case (act_reg)
                        dll_pkg::ACT_CLEAR: begin
                            head_reg  <= NIL;
                            tail_reg  <= NIL;
                            cur_reg   <= NIL;
                            free_reg  <= NIL;
                            fresh_reg <= '0;
                        end
                        dll_pkg::ACT_GOFIRST: cur_reg <= head_reg;
                        dll_pkg::ACT_GOLAST:  cur_reg <= tail_reg;
                        dll_pkg::ACT_GETFIRST, dll_pkg::ACT_GETLAST: begin
                            err_reg <= 1'b1;
                        end
                        dll_pkg::ACT_GET: begin
                            if (live(cur_reg)) rd_reg <= cval_reg;
                            else err_reg <= 1'b1;
                        end
                        dll_pkg::ACT_NEXT: if (live(cur_reg)) cur_reg <= cnext_reg;
                        dll_pkg::ACT_PREV: if (live(cur_reg)) cur_reg <= cprev_reg;
                        default: ;
                    endcase
                end
                dll_pkg::CMD_UNLINK: begin
                    if (live(tprev_reg)) begin
                        pn_we_reg <= 1'b1;
                        pn_a_reg  <= tprev_reg[IW-1:0];
                        pn_d_reg  <= tnext_reg;
                    end else begin
                        head_reg <= tnext_reg;
                    end
                    if (live(tnext_reg)) begin
                        pp_we_reg <= 1'b1;
                        pp_a_reg  <= tnext_reg[IW-1:0];
                        pp_d_reg  <= tprev_reg;
                    end else begin
                        tail_reg <= tprev_reg;
                    end
                    if (cur_reg == tgt_reg) cur_reg <= NIL;
                    free_reg <= tgt_reg;
                end
                dll_pkg::CMD_INSERT: begin
                    if (ins_sel) begin
                        if (free_avail || live(fresh_reg)) begin
                            if (free_avail) free_reg <= fnext_reg;
                            else fresh_reg <= fresh_reg + 1'b1;
                            if (live(p_reg)) begin
                                pn_we_reg <= 1'b1;
                                pn_a_reg  <= p_reg[IW-1:0];
                                pn_d_reg  <= new_n;
                            end else begin
                                head_reg <= new_n;
                            end
                            if (live(q_reg)) begin
                                pp_we_reg <= 1'b1;
                                pp_a_reg  <= q_reg[IW-1:0];
                                pp_d_reg  <= new_n;
                            end else begin
                                tail_reg <= new_n;
                            end
                        end else begin
                            err_reg <= 1'b1;
                        end
                    end
                end
                default: ;
            endcase
            // get first / last take the end node's value from the read port.
            if (cmd == dll_pkg::CMD_SIMPLE && act_reg == dll_pkg::ACT_GETFIRST
                && live(head_reg)) begin
                err_reg <= 1'b0;
                rd_reg  <= rval_reg;
            end
            if (cmd == dll_pkg::CMD_SIMPLE && act_reg == dll_pkg::ACT_GETLAST
                && live(tail_reg)) begin
                err_reg <= 1'b0;
                rd_reg  <= rval_reg;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/doubly_linked_list_with_cursor.sv @@
// ----------------------------------------------------------------------------
// doubly_linked_list_with_cursor
// Linked list over a fixed node pool with head, tail and an active cursor.
// ----------------------------------------------------------------------------
// One operation in flight: the next transaction is accepted only after the result is taken.
// Reset: pointers go to the null marker and the bump counter to zero; the
// node memories are not cleared.
`default_nettype none

module doubly_linked_list_with_cursor #(
    parameter int NODES = dll_pkg::NODES_DEFAULT
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire dll_pkg::in_item_t  s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output dll_pkg::out_item_t      m_data
);

    dll_pkg::cmd_t    cmd;
    dll_pkg::status_t stat;

    dll_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    dll_dpath #(.NODES(NODES)) u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_item  (s_data),
        .cmd     (cmd),
        .stat    (stat),
        .m_item  (m_data)
    );

endmodule

`default_nettype wire

@@ rtl/dll_checker.sv @@
// ----------------------------------------------------------------------------
// dll_checker
// Port-level checks for the linked list block.
// ----------------------------------------------------------------------------
`default_nettype none

module dll_checker (
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              s_valid,
    input wire logic              s_ready,
    input wire dll_pkg::in_item_t s_data,
    input wire logic              m_valid,
    input wire logic              m_ready,
    input wire dll_pkg::out_item_t m_data
);

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("accept while result pending");

    a_no_quick_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !m_valid) else $error("result too early");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.error) |-> m_data.value_out == 32'sd0)
        else $error("error with data");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result dropped");

endmodule

bind doubly_linked_list_with_cursor dll_checker u_dll_checker (.*);

`default_nettype wire

@@ bench/tb_doubly_linked_list_with_cursor.sv @@
// ----------------------------------------------------------------------------
// tb_doubly_linked_list_with_cursor
// Drives list operations through the valid/ready input channel and checks
// every result against a software copy of the node pool, head, tail, cursor,
// free list and bump counter. A directed table covers the corner cases, then
// random traffic runs through four idling phases.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_doubly_linked_list_with_cursor;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODES = 64;
    localparam int NIL = NODES;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    dll_pkg::in_item_t  s_data;
    logic               m_valid;
    logic               m_ready;
    dll_pkg::out_item_t m_data;

    doubly_linked_list_with_cursor #(.NODES(NODES)) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // list model state
    logic signed [31:0] pool_value [NODES];
    int                 pool_next  [NODES];
    int                 pool_prev  [NODES];
    int                 head_ptr;
    int                 tail_ptr;
    int                 cursor_ptr;
    int                 free_ptr;
    int                 fresh_ptr;
    int                 list_len;

    dll_pkg::out_item_t expected_results [$];
    int                 error_count;
    int                 send_idle_pct;
    int                 recv_stall_pct;

    typedef struct {
        dll_pkg::action_t   act;
        logic signed [31:0] val;
        logic               known;
        dll_pkg::out_item_t res;
    } row_t;

    function automatic bit is_live(int i);
        return i >= 0 && i < NODES;
    endfunction

    function automatic int take_node();
        int n;
        if (is_live(free_ptr)) begin
            n = free_ptr;
            free_ptr = pool_next[n];
            return n;
        end
        if (fresh_ptr < NODES) begin
            n = fresh_ptr;
            fresh_ptr++;
            return n;
        end
        return NIL;
    endfunction

    function automatic void drop_node(int n);
        int p;
        int q;
        if (!is_live(n)) return;
        p = pool_prev[n];
        q = pool_next[n];
        if (is_live(p)) pool_next[p] = q; else head_ptr = q;
        if (is_live(q)) pool_prev[q] = p; else tail_ptr = p;
        if (cursor_ptr == n) cursor_ptr = NIL;
        pool_next[n] = free_ptr;
        free_ptr = n;
        list_len--;
    endfunction

    function automatic bit link_node(int p, int q, logic signed [31:0] v);
        int n;
        n = take_node();
        if (!is_live(n)) return 0;
        pool_value[n] = v;
        pool_prev[n] = p;
        pool_next[n] = q;
        if (is_live(p)) pool_next[p] = n; else head_ptr = n;
        if (is_live(q)) pool_prev[q] = n; else tail_ptr = n;
        list_len++;
        return 1;
    endfunction

    function automatic void clear_list();
        head_ptr = NIL;
        tail_ptr = NIL;
        cursor_ptr = NIL;
        free_ptr = NIL;
        fresh_ptr = 0;
        list_len = 0;
    endfunction

    function automatic dll_pkg::out_item_t apply_operation(logic [4:0] act,
                                                           logic signed [31:0] v);
        dll_pkg::out_item_t r;
        int c;
        r = '0;
        c = cursor_ptr;
        case (act)
            dll_pkg::ACT_CLEAR:     clear_list();
            dll_pkg::ACT_INSFIRST:  r.error = !link_node(NIL, head_ptr, v);
            dll_pkg::ACT_INSLAST:   r.error = !link_node(tail_ptr, NIL, v);
            dll_pkg::ACT_GOFIRST:   cursor_ptr = head_ptr;
            dll_pkg::ACT_GOLAST:    cursor_ptr = tail_ptr;
            dll_pkg::ACT_GETFIRST:  if (is_live(head_ptr)) r.value_out = pool_value[head_ptr];
                                    else r.error = 1;
            dll_pkg::ACT_GETLAST:   if (is_live(tail_ptr)) r.value_out = pool_value[tail_ptr];
                                    else r.error = 1;
            dll_pkg::ACT_DELFIRST:  drop_node(head_ptr);
            dll_pkg::ACT_DELLAST:   drop_node(tail_ptr);
            dll_pkg::ACT_DELAFTER:  if (is_live(c)) drop_node(pool_next[c]);
            dll_pkg::ACT_DELBEFORE: if (is_live(c)) drop_node(pool_prev[c]);
            dll_pkg::ACT_INSAFTER:  if (is_live(c)) r.error = !link_node(c, pool_next[c], v);
            dll_pkg::ACT_INSBEFORE: if (is_live(c)) r.error = !link_node(pool_prev[c], c, v);
            dll_pkg::ACT_GET:       if (is_live(c)) r.value_out = pool_value[c];
                                    else r.error = 1;
            dll_pkg::ACT_SET:       if (is_live(c)) pool_value[c] = v;
            dll_pkg::ACT_NEXT:      if (is_live(c)) cursor_ptr = pool_next[c];
            dll_pkg::ACT_PREV:      if (is_live(c)) cursor_ptr = pool_prev[c];
            default: ;
        endcase
        if (!is_live(cursor_ptr)) cursor_ptr = NIL;
        r.cursor_valid = is_live(cursor_ptr);
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #50ms;
        $display("Simulation FAILED");
        $finish;
    end

    // result checking and receiver stalls
    always @(posedge aclk) begin
        dll_pkg::out_item_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result");
            end else begin
                e = expected_results.pop_front();
                if (m_data.value_out !== e.value_out)
                    report_mismatch($sformatf("value_out %0d exp %0d",
                                              m_data.value_out, e.value_out));
                if (m_data.error !== e.error)
                    report_mismatch($sformatf("error %0b exp %0b", m_data.error, e.error));
                if (m_data.cursor_valid !== e.cursor_valid)
                    report_mismatch($sformatf("cursor_valid %0b exp %0b",
                                              m_data.cursor_valid, e.cursor_valid));
            end
        end
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_item(logic [4:0] act, logic signed [31:0] v, bit known,
                             dll_pkg::out_item_t res);
        dll_pkg::out_item_t p;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= '{action: act, value_in: v};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        p = apply_operation(act, v);
        if (known && p !== res)
            report_mismatch($sformatf("predictor disagrees with table, action %0d", act));
        expected_results.push_back(p);
    endtask

    function automatic logic signed [31:0] random_value();
        case ($urandom_range(3))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [4:0] random_action();
        int k;
        k = $urandom_range(99);
        if (k < 2) return dll_pkg::ACT_CLEAR;
        if (k < 5) return 5'($urandom_range(31, 17));
        if (list_len < 8 && k < 45)
            return 5'($urandom_range(dll_pkg::ACT_INSFIRST, dll_pkg::ACT_INSLAST));
        if (list_len > 56 && k < 45)
            return 5'($urandom_range(dll_pkg::ACT_DELFIRST, dll_pkg::ACT_DELBEFORE));
        if (!is_live(cursor_ptr) && k < 60)
            return 5'($urandom_range(dll_pkg::ACT_GOFIRST, dll_pkg::ACT_GOLAST));
        return 5'($urandom_range(dll_pkg::ACT_INSFIRST, dll_pkg::ACT_PREV));
    endfunction

    initial begin
        row_t rows [$];
        dll_pkg::out_item_t none;
        int phase;
        none = '0;
        error_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        clear_list();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        rows = '{
            '{dll_pkg::ACT_GETFIRST,  32'sd0,        1, '{32'sd0, 1'b1, 1'b0}},
            '{dll_pkg::ACT_GETLAST,   32'sd0,        1, '{32'sd0, 1'b1, 1'b0}},
            '{dll_pkg::ACT_GET,       32'sd0,        1, '{32'sd0, 1'b1, 1'b0}},
            '{dll_pkg::ACT_DELFIRST,  32'sd0,        1, '{32'sd0, 1'b0, 1'b0}},
            '{dll_pkg::ACT_DELLAST,   32'sd0,        1, '{32'sd0, 1'b0, 1'b0}},
            '{dll_pkg::ACT_INSAFTER,  32'sd5,        1, '{32'sd0, 1'b0, 1'b0}},
            '{dll_pkg::ACT_NEXT,      32'sd0,        1, '{32'sd0, 1'b0, 1'b0}},
            '{dll_pkg::ACT_INSFIRST,  32'sh7fffffff, 1, '{32'sd0, 1'b0, 1'b0}},
            '{dll_pkg::ACT_INSLAST,   32'sh80000000, 1, '{32'sd0, 1'b0, 1'b0}},
            '{dll_pkg::ACT_GETFIRST,  32'sd0,        1, '{32'sh7fffffff, 1'b0, 1'b0}},
            '{dll_pkg::ACT_GETLAST,   32'sd0,        1, '{32'sh80000000, 1'b0, 1'b0}},
            '{dll_pkg::ACT_GOFIRST,   32'sd0,        0, none},
            '{dll_pkg::ACT_DELBEFORE, 32'sd0,        0, none},
            '{dll_pkg::ACT_INSAFTER,  32'sh5a5a5a5a, 0, none},
            '{dll_pkg::ACT_INSBEFORE, -32'sd1,       0, none},
            '{dll_pkg::ACT_SET,       32'sh12345678, 0, none},
            '{dll_pkg::ACT_GET,       32'sd0,        0, none},
            '{dll_pkg::ACT_GOLAST,    32'sd0,        0, none},
            '{dll_pkg::ACT_DELAFTER,  32'sd0,        0, none},
            '{dll_pkg::ACT_NEXT,      32'sd0,        0, none},
            '{dll_pkg::ACT_GOFIRST,   32'sd0,        0, none},
            '{dll_pkg::ACT_PREV,      32'sd0,        0, none},
            '{dll_pkg::ACT_GOLAST,    32'sd0,        0, none},
            '{dll_pkg::ACT_DELLAST,   32'sd0,        0, none},
            '{dll_pkg::ACT_QUERY,     32'sd0,        0, none}
        };
        foreach (rows[i])
            send_item(rows[i].act, rows[i].val, rows[i].known, rows[i].res);
        send_item(5'd31, 32'shffffffff, 0, none);

        // fill the pool past its capacity to reach the full case
        send_item(dll_pkg::ACT_CLEAR, 32'sd0, 0, none);
        repeat (NODES + 2) send_item(dll_pkg::ACT_INSLAST, random_value(), 0, none);
        send_item(dll_pkg::ACT_GOFIRST, 32'sd0, 0, none);
        send_item(dll_pkg::ACT_INSAFTER, 32'sd1, 0, none);
        send_item(dll_pkg::ACT_INSBEFORE, 32'sd1, 0, none);
        send_item(dll_pkg::ACT_CLEAR, 32'sd0, 0, none);

        for (phase = 0; phase < 4; phase++) begin
            send_idle_pct  = (phase == 1 || phase == 3) ? ((phase == 3) ? 26 : 58) : 0;
            recv_stall_pct = (phase == 2 || phase == 3) ? ((phase == 3) ? 26 : 58) : 0;
            repeat (250) send_item(random_action(), random_value(), 0, none);
        end

        s_valid <= 1'b0;
        fork
            wait (expected_results.size() == 0);
            repeat (20000) @(posedge aclk);
        join_any
        disable fork;
        repeat (20) @(posedge aclk);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
